// ----- rtl/sbba_pkg.sv -----
// Shared types and constants of the span bitmap block allocator.
`timescale 1ns / 1ps

package sbba_pkg;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 17;
  localparam int BATCH_W    = 7;
  localparam int FREE_W     = 9;
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;
  localparam int MIN_BLOCK  = 8;
  localparam int RST_BLOCK  = 64;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // configuration register indexes
  localparam logic CFG_SPAN_BASE  = 1'b0;
  localparam logic CFG_BLOCK_SIZE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_LOAD,
    S_A_SCAN,
    S_A_DRAIN,
    S_F_CHK,
    S_F_DIV,
    S_F_MOD
  } state_t;

  typedef struct packed {
    logic vld;
    logic last;
  } grant_tag_t;

endpackage

// ----- rtl/span_bitmap_block_allocator.sv -----
// Top level of the span bitmap block allocator: request sequencer, counters and result register.
// Usage:
//   Requests: drive start with in_req_type, in_batch_max and in_block_addr; an item is
//   taken at a rising edge with start high and busy low.
//   Results: out_valid marks each result for exactly one cycle; the receiver cannot stall.
//   An allocate item gives one result per granted block, in rising index order, the last
//   flagged by out_is_last; with nothing to grant it gives one empty result.
//   A free item gives one result.
//   Configuration: cfg_valid with cfg_index and cfg_data, always ready; write only while idle.
// Flow:
//   Allocate (one memory read port): the first result passes the bitmap read, the word load,
//   the scan, the address stage and the result register; then one grant a cycle within a
//   bitmap word, held by a load at each new word and a scan of a word with nothing free.
//   busy drops in the cycle that carries the last grant's result.
//   Empty allocate: result the cycle after the item, block stays ready.
//   Free: range check, divider (one bit a cycle), bitmap read, then clearing state; busy
//   drops with the result. An address outside the span is answered by the range check.
// Reset: synchronous; every block free, span base 0, block size 64. Word valid bits are
//   cleared at once, so no clearing pass is needed.
`timescale 1ns / 1ps

module span_bitmap_block_allocator
  import sbba_pkg::*;
#(
  parameter int NUM_BLOCKS = 256,
  parameter int MAP_WORDS  = 8,
  parameter int MAX_BATCH  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [BATCH_W-1:0] in_batch_max,
  input  logic [ADDR_W-1:0]  in_block_addr,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_block_addr_out,
  output logic               out_granted,
  output logic               out_is_last,
  output logic               out_status,
  output logic               out_span_full,
  output logic               out_span_empty,
  output logic [FREE_W-1:0]  out_free_left,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data
);

  localparam int SPAN_BLOCKS = (NUM_BLOCKS < MAP_WORDS * WORD_BITS) ?
                               NUM_BLOCKS : MAP_WORDS * WORD_BITS;
  localparam int SPAN_WORDS  = (SPAN_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW          = (SPAN_WORDS > 1) ? $clog2(SPAN_WORDS) : 1;
  localparam int IDXW        = $clog2(SPAN_BLOCKS);
  localparam int LW          = IDXW + SIZE_W;
  localparam int CW          = $clog2(SPAN_BLOCKS + 1);
  localparam int MW          = (CW > BATCH_W) ? CW : BATCH_W;
  localparam int LAST_WORD   = SPAN_WORDS - 1;
  localparam int LAST_BITS   = SPAN_BLOCKS - LAST_WORD * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_BITS == WORD_BITS) ? '1 :
                                   WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

  function automatic logic [WORD_BITS-1:0] span_mask(input logic [AW-1:0] w);
    span_mask = (w == AW'(LAST_WORD)) ? LAST_MASK : '1;
  endfunction

  // configuration
  logic [ADDR_W-1:0] span_base_r;
  logic [SIZE_W-1:0] block_size_r;
  logic [SIZE_W-1:0] esize;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     free_r, free_nxt;
  logic [BATCH_W-1:0] rem_r;
  logic [AW-1:0]     word_r;
  logic [WORD_BITS-1:0] cur_r;
  logic [ADDR_W-1:0] off_r;
  logic              neg_r;
  logic [LW-1:0]     limit_r;

  logic              accept;
  logic [BATCH_W-1:0] want_b, want;
  logic [WORD_BITS-1:0] avail, onehot, cur_upd;
  logic [WORD_SHIFT-1:0] pick_bit;
  logic              more;
  logic              in_range;

  // memory ports
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_BITS-1:0] rd_data, wr_data;

  // divider
  logic              div_start, div_done;
  logic [IDXW-1:0]   div_q;
  logic              bit_set;
  logic [CW-1:0]     free_mod;

  // address stage
  grant_tag_t        issue_tag, ag_tag;
  logic [ADDR_W-1:0] ag_addr;

  // result register
  logic              out_ld;
  logic [ADDR_W-1:0] out_addr_nxt;
  logic              out_granted_nxt, out_last_nxt, out_status_nxt;
  logic [CW-1:0]     out_free_nxt;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_granted_r, out_last_r, out_status_r;
  logic              out_full_r, out_empty_r;
  logic [FREE_W-1:0] out_free_r;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign esize     = (block_size_r < SIZE_W'(MIN_BLOCK)) ? SIZE_W'(MIN_BLOCK) : block_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_base_r  <= '0;
      block_size_r <= SIZE_W'(RST_BLOCK);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPAN_BASE:  span_base_r  <= cfg_data;
        CFG_BLOCK_SIZE: block_size_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // grant count: batch, capped by the batch limit and by what is free
  assign want_b = (in_batch_max > BATCH_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH) : in_batch_max;
  assign want   = (MW'(want_b) > MW'(free_r)) ? BATCH_W'(free_r) : want_b;

  // scan of the current word
  assign avail = ~cur_r & span_mask(word_r);

  always_comb begin
    pick_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pick_bit = WORD_SHIFT'(i);
      end
    end
  end

  assign onehot  = WORD_BITS'(1) << pick_bit;
  assign cur_upd = cur_r | onehot;
  assign more    = ((avail & ~onehot) != '0);

  assign in_range = !neg_r && (off_r < ADDR_W'(limit_r));
  assign bit_set  = rd_data[div_q[WORD_SHIFT-1:0]];
  assign free_mod = bit_set ? free_r + 1'b1 : free_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_FREE) begin
            state_nxt = S_F_CHK;
          end else if (want != '0) begin
            state_nxt = S_A_LOAD;
          end
        end
      end
      S_A_LOAD: state_nxt = S_A_SCAN;
      S_A_SCAN: begin
        if (avail == '0) begin
          state_nxt = S_A_LOAD;
        end else if (rem_r == BATCH_W'(1)) begin
          state_nxt = S_A_DRAIN;
        end else if (!more) begin
          state_nxt = S_A_LOAD;
        end
      end
      S_A_DRAIN: state_nxt = S_IDLE;
      S_F_CHK:   state_nxt = in_range ? S_F_DIV : S_IDLE;
      S_F_DIV: begin
        if (div_done) begin
          state_nxt = S_F_MOD;
        end
      end
      S_F_MOD:   state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = AW'(word_r + 1'b1);
    wr_en           = 1'b0;
    wr_addr         = word_r;
    wr_data         = cur_upd;
    div_start       = 1'b0;
    issue_tag       = '0;
    out_ld          = 1'b0;
    out_addr_nxt    = '0;
    out_granted_nxt = 1'b0;
    out_last_nxt    = 1'b1;
    out_status_nxt  = ST_OK;
    out_free_nxt    = free_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_req_type == REQ_ALLOC) begin
          if (want != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end else begin
            out_ld = 1'b1;
          end
        end
      end
      S_A_SCAN: begin
        if (avail == '0) begin
          rd_en = 1'b1;
        end else begin
          issue_tag.vld  = 1'b1;
          issue_tag.last = (rem_r == BATCH_W'(1));
          if (rem_r == BATCH_W'(1) || !more) begin
            wr_en = 1'b1;
          end
          if (rem_r != BATCH_W'(1) && !more) begin
            rd_en = 1'b1;
          end
        end
      end
      S_F_CHK: begin
        if (in_range) begin
          div_start = 1'b1;
        end else begin
          out_ld         = 1'b1;
          out_status_nxt = ST_RANGE;
        end
      end
      S_F_DIV: begin
        if (div_done) begin
          rd_en   = 1'b1;
          rd_addr = AW'(div_q >> WORD_SHIFT);
        end
      end
      S_F_MOD: begin
        wr_addr      = AW'(div_q >> WORD_SHIFT);
        wr_data      = rd_data & ~(WORD_BITS'(1) << div_q[WORD_SHIFT-1:0]);
        wr_en        = bit_set;
        out_ld       = 1'b1;
        out_free_nxt = free_mod;
      end
      default: ;
    endcase
    // grants leave the address stage one a cycle
    if (ag_tag.vld) begin
      out_ld          = 1'b1;
      out_addr_nxt    = ag_addr;
      out_granted_nxt = 1'b1;
      out_last_nxt    = ag_tag.last;
    end
  end

  always_comb begin
    free_nxt = free_r;
    if (state_r == S_IDLE && accept && in_req_type == REQ_ALLOC) begin
      free_nxt = free_r - CW'(want);
    end else if (state_r == S_F_MOD) begin
      free_nxt = free_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= CW'(SPAN_BLOCKS);
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      word_r  <= '0;
      rem_r   <= want;
      off_r   <= in_block_addr - span_base_r;
      neg_r   <= (in_block_addr < span_base_r);
      limit_r <= LW'(SPAN_BLOCKS) * LW'(esize);
    end else if (state_r == S_A_LOAD) begin
      cur_r <= rd_data;
    end else if (state_r == S_A_SCAN) begin
      if (issue_tag.vld) begin
        cur_r <= cur_upd;
        rem_r <= rem_r - 1'b1;
      end
      if (rd_en) begin
        word_r <= AW'(word_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_ld;
    end
    if (out_ld) begin
      out_addr_r    <= out_addr_nxt;
      out_granted_r <= out_granted_nxt;
      out_last_r    <= out_last_nxt;
      out_status_r  <= out_status_nxt;
      out_full_r    <= (out_free_nxt == '0);
      out_empty_r   <= (out_free_nxt == CW'(SPAN_BLOCKS));
      out_free_r    <= FREE_W'(out_free_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_block_addr_out = out_addr_r;
  assign out_granted        = out_granted_r;
  assign out_is_last        = out_last_r;
  assign out_status         = out_status_r;
  assign out_span_full      = out_full_r;
  assign out_span_empty     = out_empty_r;
  assign out_free_left      = out_free_r;

  sbba_bitmap_store #(
    .WORDS (SPAN_WORDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sbba_div #(
    .QW (IDXW),
    .DW (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (LW'(off_r)),
    .divisor  (esize),
    .done     (div_done),
    .quotient (div_q)
  );

  sbba_addr_gen #(
    .IDXW (IDXW)
  ) u_addr_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (issue_tag),
    .idx     (IDXW'({word_r, pick_bit})),
    .esize   (esize),
    .base    (span_base_r),
    .out_tag (ag_tag),
    .addr    (ag_addr)
  );

`ifndef ASSERT_OFF
  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted item neither started work nor gave a result");

  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_SCAN) |-> (rem_r != '0))
    else $error("scanning with no grants left");

  a_write_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr <= AW'(LAST_WORD)))
    else $error("bitmap write beyond the span");

  a_grant_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> !out_span_empty)
    else $error("granted block reported with the span empty");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(SPAN_BLOCKS))
    else $error("free count above span size");
`endif

endmodule

// ----- rtl/sbba_bitmap_store.sv -----
// Allocation bitmap memory with per-word valid bits that read as all free after reset.
`timescale 1ns / 1ps

module sbba_bitmap_store
  import sbba_pkg::*;
#(
  parameter int WORDS = 8,
  parameter int AW    = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  // a word never written holds no taken blocks
  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ----- rtl/sbba_div.sv -----
// Restoring divider that turns a span offset into a block index, one quotient bit a cycle.
`timescale 1ns / 1ps

module sbba_div
  import sbba_pkg::*;
#(
  parameter int QW = 8,
  parameter int DW = QW + SIZE_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [QW-1:0]     quotient
);

  localparam int CNTW = $clog2(QW + 1);

  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   dsr_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic            ge;

  assign ge = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(QW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsr_r <= DW'(divisor) << (QW - 1);
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/sbba_addr_gen.sv -----
// Address stage: block index times block size, registered, then added to the span base.
`timescale 1ns / 1ps

module sbba_addr_gen
  import sbba_pkg::*;
#(
  parameter int IDXW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grant_tag_t        in_tag,
  input  logic [IDXW-1:0]   idx,
  input  logic [SIZE_W-1:0] esize,
  input  logic [ADDR_W-1:0] base,
  output grant_tag_t        out_tag,
  output logic [ADDR_W-1:0] addr
);

  logic [IDXW+SIZE_W-1:0] prod_r;
  grant_tag_t             tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tag.vld) begin
      prod_r <= (IDXW+SIZE_W)'(idx) * (IDXW+SIZE_W)'(esize);
    end
  end

  // wraps modulo 2^48
  assign addr    = base + ADDR_W'(prod_r);
  assign out_tag = tag_r;

endmodule

// ----- test/sbba_checker.sv -----
// Checker for the span bitmap block allocator: tracks the bitmap, predicts every result and compares.
`timescale 1ns / 1ps

module sbba_checker
  import sbba_pkg::*;
#(
  parameter int NUM_BLOCKS = 256,
  parameter int MAP_WORDS  = 8,
  parameter int MAX_BATCH  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_req_type,
  input  logic [BATCH_W-1:0] in_batch_max,
  input  logic [ADDR_W-1:0]  in_block_addr,
  input  logic               out_valid,
  input  logic [ADDR_W-1:0]  out_block_addr_out,
  input  logic               out_granted,
  input  logic               out_is_last,
  input  logic               out_status,
  input  logic               out_span_full,
  input  logic               out_span_empty,
  input  logic [FREE_W-1:0]  out_free_left,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int SPAN_BLOCKS = (NUM_BLOCKS < MAP_WORDS * WORD_BITS) ?
                               NUM_BLOCKS : MAP_WORDS * WORD_BITS;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              granted;
    logic              last;
    logic              status;
    logic              full;
    logic              empty;
    logic [FREE_W-1:0] free_left;
  } grant_rec_t;

  logic [ADDR_W-1:0]    span_base_q;
  logic [SIZE_W-1:0]    block_size_q;
  logic [WORD_BITS-1:0] taken_map [MAP_WORDS];
  int unsigned          free_cnt;
  grant_rec_t           pending_grants [$];
  int                   mismatch_cnt = 0;

  // Grant or release blocks for one request and queue the results it causes.
  function automatic void apply_request(input logic req, input logic [BATCH_W-1:0] bmax,
                                        input logic [ADDR_W-1:0] addr);
    grant_rec_t        batch [$];
    grant_rec_t        rec;
    int unsigned       want;
    int unsigned       w;
    int unsigned       b;
    logic [ADDR_W-1:0] blk;
    logic [63:0]       idx;
    logic              st;
    blk = (block_size_q < MIN_BLOCK) ? ADDR_W'(MIN_BLOCK) : ADDR_W'(block_size_q);
    st  = ST_OK;
    rec = '0;
    if (req == REQ_ALLOC) begin
      want = bmax;
      if (want > MAX_BATCH) want = MAX_BATCH;
      if (want > free_cnt) want = free_cnt;
      for (int unsigned i = 0; i < SPAN_BLOCKS && batch.size() < want; i++) begin
        w = i >> WORD_SHIFT;
        b = i % WORD_BITS;
        if (!taken_map[w][b]) begin
          taken_map[w][b] = 1'b1;
          free_cnt--;
          rec = '0;
          rec.addr    = span_base_q + ADDR_W'(i) * blk;
          rec.granted = 1'b1;
          batch.push_back(rec);
        end
      end
      if (batch.size() == 0) begin
        rec = '0;
        batch.push_back(rec);
      end
    end else begin
      st = ST_RANGE;
      if (addr >= span_base_q) begin
        idx = 64'(addr - span_base_q) / 64'(blk);
        if (idx < 64'(SPAN_BLOCKS)) begin
          st = ST_OK;
          w  = int'(idx >> WORD_SHIFT);
          b  = int'(idx % WORD_BITS);
          // a block already free stays free
          if (taken_map[w][b]) begin
            taken_map[w][b] = 1'b0;
            free_cnt++;
          end
        end
      end
      batch.push_back(rec);
    end
    foreach (batch[k]) begin
      batch[k].last      = (k == batch.size() - 1);
      batch[k].status    = st;
      batch[k].full      = (free_cnt == 0);
      batch[k].empty     = (free_cnt == SPAN_BLOCKS);
      batch[k].free_left = FREE_W'(free_cnt);
      pending_grants.push_back(batch[k]);
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [ADDR_W-1:0] want,
                                    input logic [ADDR_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    grant_rec_t seen;
    grant_rec_t want;
    if (!rst_n) begin
      span_base_q  = '0;
      block_size_q = SIZE_W'(RST_BLOCK);
      foreach (taken_map[w]) taken_map[w] = '0;
      free_cnt = SPAN_BLOCKS;
      pending_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SPAN_BASE) span_base_q = cfg_data;
        else block_size_q = cfg_data[SIZE_W-1:0];
      end
      // check before queueing: a result never belongs to an item taken at the same edge
      if (out_valid) begin
        seen.addr      = out_block_addr_out;
        seen.granted   = out_granted;
        seen.last      = out_is_last;
        seen.status    = out_status;
        seen.full      = out_span_full;
        seen.empty     = out_span_empty;
        seen.free_left = out_free_left;
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual addr 0x%0h granted %0b",
                   $time, seen.addr, seen.granted);
          mismatch_cnt++;
        end else begin
          want = pending_grants.pop_front();
          cmp_field("block_addr_out", want.addr, seen.addr);
          cmp_field("granted", ADDR_W'(want.granted), ADDR_W'(seen.granted));
          cmp_field("is_last", ADDR_W'(want.last), ADDR_W'(seen.last));
          cmp_field("status", ADDR_W'(want.status), ADDR_W'(seen.status));
          cmp_field("span_full", ADDR_W'(want.full), ADDR_W'(seen.full));
          cmp_field("span_empty", ADDR_W'(want.empty), ADDR_W'(seen.empty));
          cmp_field("free_left", ADDR_W'(want.free_left), ADDR_W'(seen.free_left));
        end
      end
      if (start && !busy) apply_request(in_req_type, in_batch_max, in_block_addr);
    end
    fail_count    <= mismatch_cnt;
    pending_count <= pending_grants.size();
  end

endmodule

// ----- test/span_bitmap_block_allocator_tb.sv -----
// Testbench top for the span bitmap block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module span_bitmap_block_allocator_tb
  import sbba_pkg::*;
;

  localparam int SPAN        = 256;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic               in_req_type   = REQ_ALLOC;
  logic [BATCH_W-1:0] in_batch_max  = '0;
  logic [ADDR_W-1:0]  in_block_addr = '0;
  logic               cfg_valid     = 1'b0;
  logic               cfg_index     = CFG_SPAN_BASE;
  logic [ADDR_W-1:0]  cfg_data      = '0;

  logic               busy;
  logic               out_valid;
  logic [ADDR_W-1:0]  out_block_addr_out;
  logic               out_granted;
  logic               out_is_last;
  logic               out_status;
  logic               out_span_full;
  logic               out_span_empty;
  logic [FREE_W-1:0]  out_free_left;
  logic               cfg_ready;

  int                 fail_count;
  int                 pending_count;
  int                 quiet = 0;
  logic               idle_on;
  logic [ADDR_W-1:0]  cur_base;
  logic [SIZE_W-1:0]  cur_size;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  span_bitmap_block_allocator uut (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_batch_max, .in_block_addr,
    .out_valid, .out_block_addr_out, .out_granted, .out_is_last, .out_status,
    .out_span_full, .out_span_empty, .out_free_left,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sbba_checker chk (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_batch_max, .in_block_addr,
    .out_valid, .out_block_addr_out, .out_granted, .out_is_last, .out_status,
    .out_span_full, .out_span_empty, .out_free_left,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_count
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAIL span_bitmap_block_allocator");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Present one item and hold it until taken; start stays high unless a gap follows.
  task automatic send_req(input logic req, input logic [BATCH_W-1:0] bmax,
                          input logic [ADDR_W-1:0] addr);
    start         <= 1'b1;
    in_req_type   <= req;
    in_batch_max  <= bmax;
    in_block_addr <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    if (idle_on && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // Drop start and wait for every outstanding result and for the block to go idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy !== 1'b0);
  endtask

  task automatic retune(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SPAN_BASE;
    cfg_data  <= base;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_data  <= ADDR_W'(size);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_base = base;
    cur_size = size;
  endtask

  task automatic rand_item();
    int unsigned       pick;
    int unsigned       sub;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] noise;
    logic [BATCH_W-1:0] bmax;
    blk   = (cur_size < MIN_BLOCK) ? ADDR_W'(MIN_BLOCK) : ADDR_W'(cur_size);
    noise = ADDR_W'({$urandom, $urandom});
    bmax  = BATCH_W'($urandom);
    pick  = $urandom_range(99);
    if (pick < 58) begin
      // a block of the span, aligned or somewhere inside it
      send_req(REQ_FREE, bmax, cur_base + ADDR_W'($urandom_range(SPAN - 1)) * blk +
               ($urandom_range(1) ? noise % blk : '0));
    end else if (pick < 63) begin
      send_req(REQ_FREE, bmax, noise);
    end else if (pick < 66) begin
      if ($urandom_range(1))
        send_req(REQ_FREE, bmax, cur_base + ADDR_W'(SPAN) * blk + noise % blk);
      else
        send_req(REQ_FREE, bmax, cur_base - ADDR_W'($urandom_range(1, 300)));
    end else begin
      sub = $urandom_range(99);
      if (sub < 75)      bmax = BATCH_W'($urandom_range(1, 4));
      else if (sub < 88) bmax = BATCH_W'($urandom_range(5, 64));
      else if (sub < 95) bmax = BATCH_W'($urandom_range(65, 127));
      else               bmax = '0;
      send_req(REQ_ALLOC, bmax, noise);
    end
    if ($urandom_range(99) < 3) settle();
  endtask

  initial begin
    cur_base = '0;
    cur_size = SIZE_W'(RST_BLOCK);
    idle_on  = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the span through every batch limit, then free around its edges
    send_req(REQ_ALLOC, 7'd0, '0);
    send_req(REQ_ALLOC, 7'd1, '1);
    send_req(REQ_ALLOC, 7'd64, '0);
    send_req(REQ_ALLOC, 7'd127, '0);
    send_req(REQ_ALLOC, 7'd100, '0);
    send_req(REQ_ALLOC, 7'd70, '0);
    send_req(REQ_ALLOC, 7'd5, '0);
    send_req(REQ_FREE, 7'd0, 48'd0);
    send_req(REQ_FREE, 7'd127, 48'd677);
    send_req(REQ_FREE, 7'd0, 48'd640);
    send_req(REQ_FREE, 7'd0, 48'd16384);
    send_req(REQ_FREE, 7'd0, '1);
    send_req(REQ_FREE, 7'd0, 48'd16383);
    send_req(REQ_ALLOC, 7'd4, '0);
    settle();

    // smallest block size, no gaps from the sender
    idle_on = 1'b0;
    retune(48'h0000_1000_0000, 17'd8);
    repeat (40) rand_item();
    idle_on = 1'b1;

    // block size 65536 near the top of the address space: the span ends exactly at the top
    retune(48'hFFFF_FF00_0000, 17'd65536);
    repeat (40) rand_item();

    // block size below the floor; release every block to reach an empty span
    retune(ADDR_W'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF, 17'd3);
    for (int i = 0; i < SPAN; i++)
      send_req(REQ_FREE, BATCH_W'($urandom),
               cur_base + ADDR_W'(i) * ADDR_W'(MIN_BLOCK) + ADDR_W'($urandom_range(7)));
    repeat (20) rand_item();

    retune('0, '1);
    repeat (40) rand_item();

    retune('1, '0);
    repeat (20) rand_item();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("PASS span_bitmap_block_allocator");
    else
      $display("FAIL span_bitmap_block_allocator");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sbba_pkg.sv
rtl/sbba_bitmap_store.sv
rtl/sbba_div.sv
rtl/sbba_addr_gen.sv
rtl/span_bitmap_block_allocator.sv
test/sbba_checker.sv
test/span_bitmap_block_allocator_tb.sv
